// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed under reset guard");

// Clocked property, also checked while reset is asserted.
`define ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ===== sv/imufp_pkg.sv =====
// Types and constants of the IMU frame parser.
package imufp_pkg;

  localparam int unsigned HistDepth = 4;

  localparam logic [7:0] FrameHeader = 8'h5A;
  localparam logic [7:0] TypeRate    = 8'hAA;
  localparam logic [7:0] TypeHeading = 8'hBB;

  localparam logic signed [12:0] RateGain    = 13'sd4000;
  localparam logic signed [12:0] HeadingGain = 13'sd360;

  localparam logic [2:0] SkipReset = 3'd4;

  localparam logic KindRate    = 1'b0;
  localparam logic KindHeading = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_buffer;
  } in_req_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] raw_value;
    logic signed [27:0] scaled_q16;
  } out_req_t;

endpackage

// ===== sv/imu_frame_parser_core.sv =====
// Sliding-window IMU frame parser with checksum test and Q16 scaling.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-------------------------
//   in      | in_valid_i  | in_stall_o  | in_data_i  (in_req_t)
//   out     | out_valid_o | out_stall_i | out_data_o (out_req_t)
//
// One byte per cycle while the input is not stalled; a frame result is registered
// into the output register, or into the skid entry while the output stalls. Window
// shift, checksum test and constant multiply run in the accept cycle. Results pass
// through an output register backed by one skid entry; input stalls only while the skid entry is full.
// Reset empties the window, loads the skip count with four, drops results.
module imu_frame_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  imufp_pkg::in_req_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output imufp_pkg::out_req_t out_data_o
);
  import imufp_pkg::*;

  logic [7:0] hist_q [HistDepth];
  logic [7:0] hist_d [HistDepth];
  logic [7:0] base   [HistDepth];
  logic [2:0] skip_q, skip_d, skip_base;

  logic               in_fire, out_fire, out_free;
  logic [7:0]         sum8;
  logic               frame_ok, hit;
  logic signed [15:0] raw;
  logic signed [12:0] gain;
  logic signed [28:0] prod;
  out_req_t           res;

  out_req_t out_q, skid_q;
  logic     out_valid_q, skid_valid_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_fire;

  always_comb begin
    for (int i = 0; i < HistDepth; i++) begin
      base[i] = in_data_i.start_of_buffer ? 8'h00 : hist_q[i];
    end
    skip_base = in_data_i.start_of_buffer ? SkipReset : skip_q;

    // window after shift is base[1..3] followed by the new byte
    for (int i = 0; i < HistDepth - 1; i++) begin
      hist_d[i] = base[i + 1];
    end
    hist_d[HistDepth - 1] = in_data_i.rx_byte;

    sum8     = base[0] + base[1] + base[2] + base[3];
    frame_ok = (skip_base == 3'd0) && (base[0] == FrameHeader) &&
               (sum8 == in_data_i.rx_byte);

    if (skip_base != 3'd0) begin
      skip_d = skip_base - 3'd1;
    end else if (frame_ok) begin
      skip_d = SkipReset;
    end else begin
      skip_d = 3'd0;
    end

    raw  = {base[3], base[2]};
    gain = (base[1] == TypeRate) ? RateGain : HeadingGain;
    prod = raw * gain;
    hit  = frame_ok && ((base[1] == TypeRate) || (base[1] == TypeHeading));

    res.kind       = (base[1] == TypeRate) ? KindRate : KindHeading;
    res.raw_value  = raw;
    res.scaled_q16 = prod[27:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= 8'h00;
      end
      skip_q <= SkipReset;
    end else if (in_fire) begin
      hist_q <= hist_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_fire && hit;
      end else begin
        out_valid_q  <= in_fire && hit;
      end
    end else if (in_fire && hit) begin
      // hold the stalled result, park the new one
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire && hit) begin
          skid_q <= res;
        end
      end else if (in_fire && hit) begin
        out_q <= res;
      end
    end else if (in_fire && hit) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/imufp_checker.sv =====
// Port-level checker for the IMU frame parser, bound to the parser core.
`include "assert_macros.svh"

module imufp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input imufp_pkg::in_req_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input imufp_pkg::out_req_t out_data_o
);
  import imufp_pkg::*;

  logic signed [12:0] exp_gain;
  logic signed [28:0] exp_prod;
  logic               in_seen;

  always_comb begin
    exp_gain = (out_data_o.kind == KindRate) ? RateGain : HeadingGain;
    exp_prod = out_data_o.raw_value * exp_gain;
  end

  assign in_seen = in_valid_i && !in_stall_o && (in_data_i.rx_byte == in_data_i.rx_byte);

  `ASSERT_ANY(a_idle_in_reset, !rst_ni |-> !out_valid_o && !in_stall_o)
  `ASSERT_RST(a_scale_match, out_valid_o |-> out_data_o.scaled_q16 == exp_prod[27:0])
  `ASSERT_RST(a_stall_needs_result, in_stall_o |-> out_valid_o)
  `ASSERT_RST(a_result_from_input, $rose(out_valid_o) |-> $past(in_seen))
  `ASSERT_RST(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

endmodule

bind imu_frame_parser_core imufp_checker u_imufp_checker (.*);
